// File: rtl/pmpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmpw_pkg
// Types, codes and constants shared by the paint mode pixel writer.
// ----------------------------------------------------------------------------
package pmpw_pkg;

    // Number of bit planes in a pixel; colours are taken modulo 2^PIXEL_BITS.
    localparam int PIXEL_BITS = 8;
    localparam logic [7:0] PIX_MASK = 8'((1 << PIXEL_BITS) - 1);

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // APB address width: eight 32-bit registers at byte addresses 4*i.
    localparam int ADDR_BITS = 5;

    typedef enum logic [2:0] {
        MODE_MASK    = 3'd0,
        MODE_COLOR   = 3'd1,
        MODE_REPLACE = 3'd2,
        MODE_SMEAR   = 3'd3,
        MODE_SHADE   = 3'd4,
        MODE_BLEND   = 3'd5,
        MODE_CYCLE   = 3'd6,
        MODE_XOR     = 3'd7
    } t_paint_mode;

    typedef enum logic [1:0] {
        WOP_NONE       = 2'd0,
        WOP_WRITE      = 2'd1,
        WOP_COMPLEMENT = 2'd2
    } t_write_op;

    typedef enum logic [2:0] {
        REG_PAINT_MODE   = 3'd0,
        REG_RANGE_ENABLE = 3'd1,
        REG_RANGE_LOW    = 3'd2,
        REG_RANGE_HIGH   = 3'd3,
        REG_CLIP_LEFT    = 3'd4,
        REG_CLIP_TOP     = 3'd5,
        REG_CLIP_RIGHT   = 3'd6,
        REG_CLIP_BOTTOM  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        t_paint_mode        paint_mode;
        logic               range_enable;
        logic [7:0]         range_low;
        logic [7:0]         range_high;
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_top;
        logic signed [15:0] clip_right;
        logic signed [15:0] clip_bottom;
    } t_cfg;

    // A pixel word after classification by the front.
    typedef struct packed {
        logic       in_clip;
        logic [7:0] value;
        logic [7:0] pen;
        logic       erase;
        logic       stroke_start;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// File: rtl/pmpw_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmpw_regs
// APB register file holding the paint mode, colour range and clip box.
// ----------------------------------------------------------------------------
module pmpw_regs
    import pmpw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output t_cfg                 o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_write;

    assign w_idx   = t_reg_idx'(paddr[ADDR_BITS-1:2]);
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            unique case (w_idx)
                REG_PAINT_MODE:   n_cfg.paint_mode   = t_paint_mode'(pwdata[2:0]);
                REG_RANGE_ENABLE: n_cfg.range_enable = pwdata[0];
                REG_RANGE_LOW:    n_cfg.range_low    = pwdata[7:0];
                REG_RANGE_HIGH:   n_cfg.range_high   = pwdata[7:0];
                REG_CLIP_LEFT:    n_cfg.clip_left    = pwdata[15:0];
                REG_CLIP_TOP:     n_cfg.clip_top     = pwdata[15:0];
                REG_CLIP_RIGHT:   n_cfg.clip_right   = pwdata[15:0];
                REG_CLIP_BOTTOM:  n_cfg.clip_bottom  = pwdata[15:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.paint_mode   <= MODE_COLOR;
            r_cfg.range_enable <= 1'b0;
            r_cfg.range_low    <= 8'd0;
            r_cfg.range_high   <= 8'd255;
            r_cfg.clip_left    <= 16'sd0;
            r_cfg.clip_top     <= 16'sd0;
            r_cfg.clip_right   <= -16'sd1;
            r_cfg.clip_bottom  <= -16'sd1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Clip coordinates read back sign-extended.
    always_comb begin
        unique case (w_idx)
            REG_PAINT_MODE:   prdata = {29'd0, r_cfg.paint_mode};
            REG_RANGE_ENABLE: prdata = {31'd0, r_cfg.range_enable};
            REG_RANGE_LOW:    prdata = {24'd0, r_cfg.range_low};
            REG_RANGE_HIGH:   prdata = {24'd0, r_cfg.range_high};
            REG_CLIP_LEFT:    prdata = {{16{r_cfg.clip_left[15]}}, r_cfg.clip_left};
            REG_CLIP_TOP:     prdata = {{16{r_cfg.clip_top[15]}}, r_cfg.clip_top};
            REG_CLIP_RIGHT:   prdata = {{16{r_cfg.clip_right[15]}}, r_cfg.clip_right};
            REG_CLIP_BOTTOM:  prdata = {{16{r_cfg.clip_bottom[15]}}, r_cfg.clip_bottom};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/pmpw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmpw_front
// Accepts pixel words, tests them against the clip box and registers them.
// ----------------------------------------------------------------------------
module pmpw_front
    import pmpw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [7:0]         i_read_value,
    input  logic [7:0]         i_pen_color,
    input  logic               i_erase_active,
    input  logic               i_stroke_start,
    input  t_queue_status      i_queue,
    output logic               o_push,
    output t_item              o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    t_item n_item;
    logic  w_accept;

    assign o_push   = r_valid && !i_queue.full;
    assign o_stall  = r_valid && i_queue.full;
    assign w_accept = i_valid && !o_stall;
    assign o_item   = r_item;

    always_comb begin
        n_valid = w_accept || (r_valid && !o_push);
        n_item  = r_item;
        if (w_accept) begin
            n_item.in_clip = (i_pos_x >= i_cfg.clip_left) && (i_pos_x <= i_cfg.clip_right) &&
                             (i_pos_y >= i_cfg.clip_top)  && (i_pos_y <= i_cfg.clip_bottom);
            n_item.value        = i_read_value & PIX_MASK;
            n_item.pen          = i_pen_color & PIX_MASK;
            n_item.erase        = i_erase_active;
            n_item.stroke_start = i_stroke_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

// File: rtl/pmpw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmpw_queue
// Short first-in first-out queue of classified pixel words.
// ----------------------------------------------------------------------------
module pmpw_queue
    import pmpw_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_item         i_item,
    input  logic          i_pop,
    output t_item         o_item,
    output t_queue_status o_status
);

    t_item                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] n_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QPTR_BITS-1:0] n_rd_ptr;
    logic [QPTR_BITS:0]   r_count;
    logic [QPTR_BITS:0]   n_count;

    assign o_status.full  = (r_count == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_item         = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (QPTR_BITS+1)'(i_push) - (QPTR_BITS+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: rtl/pmpw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmpw_back
// Applies the paint mode to queued words, keeps the one-pixel history and
// holds the write decision in the output register.
// ----------------------------------------------------------------------------
module pmpw_back
    import pmpw_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  t_queue_status i_queue,
    input  t_item         i_item,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output t_write_op     o_write_op,
    output logic [7:0]    o_write_color
);

    logic       r_valid;
    t_write_op  r_op;
    t_write_op  n_op;
    logic [7:0] r_color;
    logic [7:0] n_color;
    logic [7:0] r_prev_value;
    logic [7:0] n_prev_value;
    logic       r_prev_in_range;
    logic       n_prev_in_range;
    logic       r_first_pending;
    logic       n_first_pending;
    logic       w_first;
    logic       w_here;
    logic       w_shade_ok;
    logic [8:0] w_sum;
    t_write_op  w_op;
    logic [7:0] w_color;

    assign o_pop         = !i_queue.empty && (!r_valid || !i_stall);
    assign o_valid       = r_valid;
    assign o_write_op    = r_op;
    assign o_write_color = r_color;

    assign w_here = !i_cfg.range_enable ||
                    ((i_item.value >= i_cfg.range_low) && (i_item.value <= i_cfg.range_high));
    assign w_sum  = {1'b0, i_item.value} + {1'b0, r_prev_value};

    always_comb begin
        if (i_item.erase) begin
            w_shade_ok = !(i_cfg.range_enable && ((i_item.value <= i_cfg.range_low) ||
                                                  (i_item.value > i_cfg.range_high)));
        end else begin
            w_shade_ok = !(i_cfg.range_enable && ((i_item.value < i_cfg.range_low) ||
                                                  (i_item.value >= i_cfg.range_high)));
        end
    end

    always_comb begin
        w_first         = i_item.stroke_start || r_first_pending;
        w_op            = WOP_NONE;
        w_color         = 8'd0;
        n_prev_value    = r_prev_value;
        n_prev_in_range = r_prev_in_range;
        unique case (i_cfg.paint_mode) inside
            MODE_SMEAR: begin
                if (!w_first) begin
                    w_op    = WOP_WRITE;
                    w_color = r_prev_value;
                end
                w_first      = 1'b0;
                n_prev_value = i_item.value;
            end
            MODE_SHADE: begin
                if (w_shade_ok) begin
                    w_op = WOP_WRITE;
                    if (i_item.erase) begin
                        w_color = (i_item.value - 8'd1) & PIX_MASK;
                    end else begin
                        w_color = (i_item.value + 8'd1) & PIX_MASK;
                    end
                end
            end
            MODE_BLEND: begin
                if (!w_first && w_here && r_prev_in_range) begin
                    w_op    = WOP_WRITE;
                    w_color = w_sum[8:1] & PIX_MASK;
                end
                w_first         = 1'b0;
                n_prev_value    = i_item.value;
                n_prev_in_range = w_here;
            end
            MODE_XOR: begin
                if (i_item.erase) begin
                    w_op    = WOP_WRITE;
                    w_color = i_item.pen;
                end else begin
                    w_op = WOP_COMPLEMENT;
                end
            end
            MODE_MASK, MODE_COLOR, MODE_REPLACE, MODE_CYCLE: begin
                w_op    = WOP_WRITE;
                w_color = i_item.pen;
            end
            default: begin
                w_op    = WOP_WRITE;
                w_color = i_item.pen;
            end
        endcase
        n_first_pending = w_first;
        // A pixel outside the clip box is never written; a colour only goes
        // out with a plain write.
        n_op    = i_item.in_clip ? w_op : WOP_NONE;
        n_color = (n_op == WOP_WRITE) ? w_color : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid         <= 1'b0;
            r_prev_value    <= 8'd0;
            r_prev_in_range <= 1'b0;
            r_first_pending <= 1'b0;
        end else begin
            if (o_pop) begin
                r_valid         <= 1'b1;
                r_prev_value    <= n_prev_value;
                r_prev_in_range <= n_prev_in_range;
                r_first_pending <= n_first_pending;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op    <= n_op;
            r_color <= n_color;
        end
    end

endmodule

// File: rtl/paint_mode_pixel_writer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paint_mode_pixel_writer_top
// Per-pixel paint engine: turns each brush pixel into one write decision.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   ---------------------------------------------
//  input     i_valid / o_stall    i_pos_x, i_pos_y, i_read_value, i_pen_color,
//                                 i_erase_active, i_stroke_start
//  output    o_valid / i_stall    o_write_op, o_write_color
//  config    APB psel/penable     paddr, pwdata, prdata, pready (always high)
//
// One word is taken per clock cycle and one result leaves per clock cycle
// while neither side stalls; that rate is set by the combinational mode logic
// of the back and its one-pixel history register, updated on every pop.
// Each word passes the front register, the queue and the back output register.
// Reset is synchronous and active low; it loads the register defaults,
// clears the history and empties the queue.
// A stall at the output fills the four-word queue first; only when the queue
// and the front register are both full is o_stall raised to the source.
//
// Structure: the front registers each accepted word together with its clip
// test, a short queue decouples it from the back, and the back applies the
// paint mode in order, updating the smear and blend history as it pops.
// ----------------------------------------------------------------------------
module paint_mode_pixel_writer_top
    import pmpw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input word channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [15:0]   i_pos_x,
    input  logic signed [15:0]   i_pos_y,
    input  logic [7:0]           i_read_value,
    input  logic [7:0]           i_pen_color,
    input  logic                 i_erase_active,
    input  logic                 i_stroke_start,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_write_op,
    output logic [7:0]           o_write_color,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    t_cfg          w_cfg;
    t_queue_status w_queue;
    t_item         w_front_item;
    t_item         w_back_item;
    logic          w_push;
    logic          w_pop;
    t_write_op     w_write_op;

    // Registers are only to be written while the datapath is idle, so both halves
    // read them directly; the block itself does not enforce this.
    pmpw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pmpw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_read_value   (i_read_value),
        .i_pen_color    (i_pen_color),
        .i_erase_active (i_erase_active),
        .i_stroke_start (i_stroke_start),
        .i_queue        (w_queue),
        .o_push         (w_push),
        .o_item         (w_front_item)
    );

    pmpw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_front_item),
        .i_pop    (w_pop),
        .o_item   (w_back_item),
        .o_status (w_queue)
    );

    pmpw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_queue       (w_queue),
        .i_item        (w_back_item),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_write_op    (w_write_op),
        .o_write_color (o_write_color)
    );

    assign o_write_op = w_write_op;

    // The front must never push into a full queue, nor the back pop an empty one.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_queue.full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_queue.empty))
        else $error("queue read while empty");

    // Only a plain write carries a colour.
    a_color_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (w_write_op != WOP_WRITE)) |-> (o_write_color == 8'd0))
        else $error("colour present without a write");

    // A result held under stall must not be replaced by a later pop.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !w_pop)
        else $error("result overwritten while stalled");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the paint mode pixel writer.
// Drives pixel words through the valid/stall input channel and programmes
// the mode, colour range and clip box over the APB port. A behavioural
// predictor works out the write decision of every accepted word, and each
// decision leaving the block is compared with the oldest one predicted.
// ----------------------------------------------------------------------------
module testbench;
    import pmpw_pkg::*;

    // Extra cycles waited once every predicted result has left, before the
    // configuration is touched or the run is closed.
    localparam int SETTLE_CYCLES   = 8;
    localparam int PHASES          = 14;
    localparam int WORDS_PER_PHASE = 50;
    localparam int MAX_PRINTED     = 40;

    // One pixel word as it is offered to the block.
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [7:0]         value;
        logic [7:0]         pen;
        logic               erase;
        logic               start;
    } t_pixel_word;

    // One write decision as it leaves the block.
    typedef struct {
        t_write_op  op;
        logic [7:0] color;
    } t_decision;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic signed [15:0]   i_pos_x;
    logic signed [15:0]   i_pos_y;
    logic [7:0]           i_read_value;
    logic [7:0]           i_pen_color;
    logic                 i_erase_active;
    logic                 i_stroke_start;
    logic                 o_valid;
    logic                 i_stall;
    logic [1:0]           o_write_op;
    logic [7:0]           o_write_color;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // Shadow of the block's registers and of its one-pixel history.
    t_cfg       cfg_shadow;
    logic [7:0] hist_value;
    logic       hist_in_range;
    logic       start_pending;

    // Decisions predicted for accepted words, oldest first.
    t_decision  expected_decisions[$];
    int         mismatch_count = 0;

    // Idling switches: the source inserts gaps, the sink raises stall.
    bit         source_idles = 1'b0;
    bit         sink_idles   = 1'b0;
    int         sink_run     = 0;
    bit         sink_busy    = 1'b0;

    paint_mode_pixel_writer_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_read_value   (i_read_value),
        .i_pen_color    (i_pen_color),
        .i_erase_active (i_erase_active),
        .i_stroke_start (i_stroke_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_write_op     (o_write_op),
        .o_write_color  (o_write_color),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Works out the write decision for one word and advances the history.
    // The clip test only masks the result: smear and blend still update
    // their history for pixels outside the box.
    function automatic t_decision paint_decision(t_pixel_word w);
        logic [7:0] v;
        logic [7:0] pen;
        logic [8:0] sum;
        logic       first;
        logic       in_box;
        logic       here;
        t_decision  d;

        v      = w.value & PIX_MASK;
        pen    = w.pen & PIX_MASK;
        first  = w.start || start_pending;
        in_box = (w.x >= cfg_shadow.clip_left) && (w.x <= cfg_shadow.clip_right) &&
                 (w.y >= cfg_shadow.clip_top) && (w.y <= cfg_shadow.clip_bottom);
        d.op    = WOP_NONE;
        d.color = 8'd0;

        case (cfg_shadow.paint_mode)
            MODE_SMEAR: begin
                if (!first) begin
                    d.op    = WOP_WRITE;
                    d.color = hist_value;
                end
                first      = 1'b0;
                hist_value = v;
            end
            MODE_SHADE: begin
                // Range bounds are compared as they stand, so an inverted
                // range simply never lets a shade through.
                if (w.erase) begin
                    if (!(cfg_shadow.range_enable &&
                          (v <= cfg_shadow.range_low || v > cfg_shadow.range_high))) begin
                        d.op    = WOP_WRITE;
                        d.color = (v - 8'd1) & PIX_MASK;
                    end
                end else begin
                    if (!(cfg_shadow.range_enable &&
                          (v < cfg_shadow.range_low || v >= cfg_shadow.range_high))) begin
                        d.op    = WOP_WRITE;
                        d.color = (v + 8'd1) & PIX_MASK;
                    end
                end
            end
            MODE_BLEND: begin
                here = !cfg_shadow.range_enable ||
                       (v >= cfg_shadow.range_low && v <= cfg_shadow.range_high);
                if (!first && here && hist_in_range) begin
                    sum     = {1'b0, v} + {1'b0, hist_value};
                    d.op    = WOP_WRITE;
                    d.color = sum[8:1] & PIX_MASK;
                end
                first         = 1'b0;
                hist_value    = v;
                hist_in_range = here;
            end
            MODE_XOR: begin
                if (w.erase) begin
                    d.op    = WOP_WRITE;
                    d.color = pen;
                end else begin
                    d.op = WOP_COMPLEMENT;
                end
            end
            default: begin
                d.op    = WOP_WRITE;
                d.color = pen;
            end
        endcase
        start_pending = first;

        if (!in_box || d.op != WOP_WRITE) d.color = 8'd0;
        if (!in_box) d.op = WOP_NONE;
        return d;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // Every result taken from the block is matched against the oldest
    // prediction; a result with nothing predicted is a failure in itself.
    always @(posedge i_clk) begin : check_results
        t_decision want;
        if (i_rst_n && $isunknown(o_valid)) begin
            report_mismatch("o_valid unknown", 0, 0);
        end else if (i_rst_n && o_valid && !i_stall) begin
            if (expected_decisions.size() == 0) begin
                report_mismatch("result with none expected, write_op", o_write_op, 0);
            end else begin
                want = expected_decisions.pop_front();
                if (o_write_op !== want.op)
                    report_mismatch("write_op", o_write_op, want.op);
                if (o_write_color !== want.color)
                    report_mismatch("write_color", o_write_color, want.color);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Idling of both sides
    // ------------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_stall_run(bit busy);
        int r;
        r = $urandom_range(0, 99);
        if (busy) begin
            if (r < 70) return $urandom_range(1, 2);
            if (r < 93) return $urandom_range(3, 8);
            return $urandom_range(15, 40);
        end
        if (r < 60) return $urandom_range(1, 4);
        return $urandom_range(5, 30);
    endfunction

    // The sink alternates between free and stalled runs of random length.
    always @(negedge i_clk) begin
        if (sink_run == 0) begin
            sink_busy = !sink_busy;
            sink_run  = pick_stall_run(sink_busy);
        end
        sink_run--;
        i_stall = sink_busy && sink_idles && i_rst_n;
    end

    // ------------------------------------------------------------------------
    // Word and register traffic
    // ------------------------------------------------------------------------

    // Offers one word, holding it steady until the block takes it, and then
    // records its predicted decision.
    task automatic send_word(t_pixel_word w);
        int gap;
        gap = source_idles ? pick_gap() : 0;
        @(negedge i_clk);
        repeat (gap) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_pos_x        = w.x;
        i_pos_y        = w.y;
        i_read_value   = w.value;
        i_pen_color    = w.pen;
        i_erase_active = w.erase;
        i_stroke_start = w.start;
        i_valid        = 1'b1;
        do @(posedge i_clk); while (o_stall);
        expected_decisions.push_back(paint_decision(w));
    endtask

    task automatic send_pixel(int x, int y, logic [7:0] value, logic [7:0] pen,
                              logic erase, logic start);
        t_pixel_word w;
        w.x     = x[15:0];
        w.y     = y[15:0];
        w.value = value;
        w.pen   = pen;
        w.erase = erase;
        w.start = start;
        send_word(w);
    endtask

    // Drops valid and lets every outstanding decision come out.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_decisions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_BITS'({idx, 2'b00});
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(t_reg_idx idx, output logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_BITS'({idx, 2'b00});
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Registers only change once the block has gone quiet.
    task automatic set_reg(t_reg_idx idx, logic [31:0] data);
        wait_idle();
        apb_write(idx, data);
        case (idx)
            REG_PAINT_MODE:   cfg_shadow.paint_mode   = t_paint_mode'(data[2:0]);
            REG_RANGE_ENABLE: cfg_shadow.range_enable = data[0];
            REG_RANGE_LOW:    cfg_shadow.range_low    = data[7:0];
            REG_RANGE_HIGH:   cfg_shadow.range_high   = data[7:0];
            REG_CLIP_LEFT:    cfg_shadow.clip_left    = data[15:0];
            REG_CLIP_TOP:     cfg_shadow.clip_top     = data[15:0];
            REG_CLIP_RIGHT:   cfg_shadow.clip_right   = data[15:0];
            default:          cfg_shadow.clip_bottom  = data[15:0];
        endcase
    endtask

    task automatic set_clip(int left, int top, int right, int bottom);
        set_reg(REG_CLIP_LEFT,   32'(left[15:0]));
        set_reg(REG_CLIP_TOP,    32'(top[15:0]));
        set_reg(REG_CLIP_RIGHT,  32'(right[15:0]));
        set_reg(REG_CLIP_BOTTOM, 32'(bottom[15:0]));
    endtask

    task automatic set_range(logic enable, logic [7:0] low, logic [7:0] high);
        set_reg(REG_RANGE_ENABLE, 32'(enable));
        set_reg(REG_RANGE_LOW,    32'(low));
        set_reg(REG_RANGE_HIGH,   32'(high));
    endtask

    task automatic set_mode(t_paint_mode mode);
        set_reg(REG_PAINT_MODE, 32'(mode));
    endtask

    function automatic logic [31:0] reg_field_mask(t_reg_idx idx);
        case (idx)
            REG_PAINT_MODE:                return 32'h7;
            REG_RANGE_ENABLE:              return 32'h1;
            REG_RANGE_LOW, REG_RANGE_HIGH: return 32'hFF;
            default:                       return 32'hFFFF;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic int clamp16(int v);
        if (v < -32768) return -32768;
        if (v > 32767) return 32767;
        return v;
    endfunction

    function automatic int rand16();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // A coordinate in or just around the span between the two clip bounds.
    function automatic int pick_coord(int a, int b);
        int lo;
        int hi;
        lo = clamp16(((a < b) ? a : b) - 3);
        hi = clamp16(((a > b) ? a : b) + 3);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Pixel values lean towards the range bounds and the two extremes.
    function automatic logic [7:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2, 3:    return cfg_shadow.range_low + 8'($urandom_range(0, 2)) - 8'd1;
            4, 5:    return cfg_shadow.range_high + 8'($urandom_range(0, 2)) - 8'd1;
            default: return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // The reset clip box is empty, so nothing may be written straight after
    // reset whatever the pixel.
    task automatic test_reset_defaults();
        send_pixel(0, 0, 8'h00, 8'hFF, 1'b0, 1'b0);
        send_pixel(-1, -1, 8'hFF, 8'h00, 1'b1, 1'b1);
        send_pixel(0, -1, 8'h5A, 8'hA5, 1'b0, 1'b0);
    endtask

    // Each register is written with all ones, all zeros and a random value,
    // and read back each time.
    task automatic test_register_access();
        logic [31:0] data;
        logic [31:0] got;
        for (int pass = 0; pass < 3; pass++) begin
            for (int i = 0; i < 8; i++) begin
                data = (pass == 0) ? 32'hFFFF_FFFF : (pass == 1) ? 32'h0 : $urandom;
                set_reg(t_reg_idx'(i), data);
                apb_read(t_reg_idx'(i), got);
                if (((got ^ data) & reg_field_mask(t_reg_idx'(i))) != 32'h0)
                    report_mismatch($sformatf("readback of register %0d", i),
                                    got & reg_field_mask(t_reg_idx'(i)),
                                    data & reg_field_mask(t_reg_idx'(i)));
            end
        end
    endtask

    // One pass over every mode and the corner cases of each.
    task automatic test_directed_modes();
        set_clip(-32768, -32768, 32767, 32767);
        set_range(1'b0, 8'd0, 8'd255);

        // Plain modes write the pen, at both corners of the coordinate space.
        set_mode(MODE_COLOR);
        send_pixel(-32768, -32768, 8'h00, 8'hFF, 1'b0, 1'b0);
        send_pixel(32767, 32767, 8'hFF, 8'h00, 1'b1, 1'b0);
        set_mode(MODE_MASK);
        send_pixel(5, -5, 8'h3C, 8'hA5, 1'b0, 1'b0);
        set_mode(MODE_REPLACE);
        send_pixel(-7, 9, 8'hC3, 8'h5A, 1'b1, 1'b0);
        set_mode(MODE_CYCLE);
        send_pixel(100, 200, 8'h81, 8'h7E, 1'b0, 1'b1);

        // Xor complements unless erasing, when it writes the pen.
        set_mode(MODE_XOR);
        send_pixel(1, 1, 8'h12, 8'h5A, 1'b1, 1'b0);
        send_pixel(1, 2, 8'h12, 8'h5A, 1'b0, 1'b0);

        // Shade wraps at both ends when no range is in force.
        set_mode(MODE_SHADE);
        send_pixel(3, 3, 8'hFF, 8'h00, 1'b0, 1'b0);
        send_pixel(3, 4, 8'h00, 8'h00, 1'b1, 1'b0);
        // With a range, the top bound is left alone when adding and the
        // bottom bound when subtracting.
        set_range(1'b1, 8'd10, 8'd20);
        send_pixel(3, 5, 8'd20, 8'h00, 1'b0, 1'b0);
        send_pixel(3, 6, 8'd10, 8'h00, 1'b1, 1'b0);
        send_pixel(3, 7, 8'd19, 8'h00, 1'b0, 1'b0);

        // Blend: first pixel skipped, then writes only while both this and
        // the previous value lie in the range.
        set_mode(MODE_BLEND);
        send_pixel(4, 0, 8'd12, 8'h00, 1'b0, 1'b1);
        send_pixel(4, 1, 8'd20, 8'h00, 1'b0, 1'b0);
        send_pixel(4, 2, 8'd21, 8'h00, 1'b0, 1'b0);
        send_pixel(4, 3, 8'd15, 8'h00, 1'b0, 1'b0);

        // A stroke start seen in another mode stays pending into smear.
        set_mode(MODE_COLOR);
        send_pixel(6, 0, 8'd1, 8'd2, 1'b0, 1'b1);
        set_mode(MODE_SMEAR);
        send_pixel(6, 1, 8'd7, 8'd2, 1'b0, 1'b0);
        send_pixel(6, 2, 8'd9, 8'd2, 1'b0, 1'b0);

        // A one-pixel clip box: only the pixel on it is written.
        set_clip(0, 0, 0, 0);
        set_mode(MODE_COLOR);
        send_pixel(1, 0, 8'd0, 8'd77, 1'b0, 1'b0);
        send_pixel(0, 0, 8'd0, 8'd77, 1'b0, 1'b0);
        send_pixel(0, 1, 8'd0, 8'd77, 1'b0, 1'b0);

        // An inverted range means shade never writes.
        set_range(1'b1, 8'd30, 8'd20);
        set_mode(MODE_SHADE);
        send_pixel(0, 0, 8'd25, 8'd0, 1'b0, 1'b0);

        // An inverted clip box means nothing is written at all.
        set_clip(5, 0, 4, 0);
        set_mode(MODE_COLOR);
        send_pixel(5, 0, 8'd0, 8'd99, 1'b0, 1'b0);
    endtask

    // Picks a mode, a colour range and a clip box for one phase. The first
    // phases go through the extreme ranges and boxes in turn.
    task automatic randomise_setup(int phase);
        int         kind;
        int         l;
        int         t;
        int         r;
        int         b;
        logic [7:0] lo;
        logic [7:0] hi;

        if ($urandom_range(0, 2) == 0)
            set_mode(t_paint_mode'($urandom_range(0, 7)));
        else
            set_mode(t_paint_mode'($urandom_range(MODE_SMEAR, MODE_BLEND)));

        kind = (phase < 4) ? phase : $urandom_range(0, 3);
        lo   = 8'($urandom);
        hi   = 8'($urandom);
        case (kind)
            0: begin lo = 8'd0; hi = 8'd255; end
            1: hi = lo;
            2: if (lo <= hi) begin lo = hi + 8'd1; hi = hi; end
            default: if (lo > hi) begin lo = lo ^ hi; hi = lo ^ hi; lo = lo ^ hi; end
        endcase
        set_range(1'($urandom_range(0, 1)), lo, hi);

        kind = (phase < 4) ? phase : $urandom_range(0, 3);
        case (kind)
            0: begin l = -32768; t = -32768; r = 32767; b = 32767; end
            1: begin
                l = rand16(); r = clamp16(l - int'($urandom_range(1, 5)));
                t = rand16(); b = clamp16(t + int'($urandom_range(0, 20)));
                if (l <= r) begin l = 32767; r = 32766; end
            end
            2: begin
                l = rand16(); r = clamp16(l + int'($urandom_range(0, 30)));
                t = rand16(); b = clamp16(t + int'($urandom_range(0, 30)));
            end
            default: begin
                l = 32767 - int'($urandom_range(0, 20)); r = 32767;
                t = -32768; b = -32768 + int'($urandom_range(0, 20));
            end
        endcase
        set_clip(l, t, r, b);
    endtask

    // Mostly well-formed strokes wandering around the clip box, with stray
    // words and strokes that lack their start flag mixed in.
    task automatic test_random_strokes();
        int         sent;
        int         len;
        int         x;
        int         y;
        logic [7:0] pen;
        logic       erase;
        logic       opened;

        for (int phase = 0; phase < PHASES; phase++) begin
            source_idles = (phase % 4 != 1);
            sink_idles   = (phase % 4 != 2);
            randomise_setup(phase);
            sent = 0;
            while (sent < WORDS_PER_PHASE) begin
                len    = $urandom_range(1, 12);
                x      = pick_coord(cfg_shadow.clip_left, cfg_shadow.clip_right);
                y      = pick_coord(cfg_shadow.clip_top, cfg_shadow.clip_bottom);
                pen    = 8'($urandom);
                erase  = ($urandom_range(0, 3) == 0);
                opened = ($urandom_range(0, 4) != 0);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_pixel(rand16(), rand16(), 8'($urandom), 8'($urandom),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    else
                        send_pixel(x, y, pick_value(), pen, erase, opened && k == 0);
                    x = clamp16(x + int'($urandom_range(0, 2)) - 1);
                    y = clamp16(y + int'($urandom_range(0, 2)) - 1);
                    sent++;
                end
            end
        end
        source_idles = 1'b0;
        sink_idles   = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stall        = 1'b0;
        i_pos_x        = '0;
        i_pos_y        = '0;
        i_read_value   = '0;
        i_pen_color    = '0;
        i_erase_active = 1'b0;
        i_stroke_start = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;

        cfg_shadow.paint_mode   = MODE_COLOR;
        cfg_shadow.range_enable = 1'b0;
        cfg_shadow.range_low    = 8'd0;
        cfg_shadow.range_high   = 8'd255;
        cfg_shadow.clip_left    = 16'sd0;
        cfg_shadow.clip_top     = 16'sd0;
        cfg_shadow.clip_right   = -16'sd1;
        cfg_shadow.clip_bottom  = -16'sd1;
        hist_value              = 8'd0;
        hist_in_range           = 1'b0;
        start_pending           = 1'b0;

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_register_access();
        test_directed_modes();
        test_random_strokes();
        wait_idle();

        if (mismatch_count == 0) begin
            $display("[paint_mode_pixel_writer_top] OK");
        end else begin
            $display("[paint_mode_pixel_writer_top] ERROR");
        end
        $finish;
    end

    // Generous bound: well above the slowest correct run with the longest
    // gaps and stalls on every word.
    initial begin
        #2_000_000;
        $display("[paint_mode_pixel_writer_top] ERROR");
        $finish;
    end

endmodule

// File: paint_mode_pixel_writer_top.f
rtl/pmpw_pkg.sv
rtl/pmpw_regs.sv
rtl/pmpw_front.sv
rtl/pmpw_queue.sv
rtl/pmpw_back.sv
rtl/paint_mode_pixel_writer_top.sv
tb/testbench.sv
